// ===== rtl/assert_macros.svh =====
// assertion macros for the depth smoother rtl
// no dependencies; taken in by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define BDSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, held off during reset
`define BDSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== rtl/bdsm_pkg.sv =====
// shared types, constants and the exponential table of the depth smoother
// no dependencies; used by every module of the block except bdsm_ram

package bdsm_pkg;

   // geometry
   localparam int HALF_WIDTH  = 3;
   localparam int MAX_WIDTH   = 1024;
   localparam int EXP_ENTRIES = 256;
   localparam int DEPTH_BITS  = 16;

   localparam int WIN_SIZE    = 2 * HALF_WIDTH + 1;
   localparam int TAP_COUNT   = WIN_SIZE * WIN_SIZE;
   localparam int RING_ROWS   = 2 * HALF_WIDTH + 2;
   localparam int LINE_DEPTH  = RING_ROWS * MAX_WIDTH;
   localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
   localparam int RING_BITS   = $clog2(RING_ROWS);
   localparam int RING_SUM_BITS = $clog2(3 * RING_ROWS);
   localparam int OFF_BITS    = $clog2(WIN_SIZE);
   localparam int WIDTH_LIMIT = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int HEIGHT_LIMIT = 1024;

   // field widths
   localparam int PIX_BITS   = 16;
   localparam int POS_BITS   = 10;
   localparam int SIZE_BITS  = 11;
   localparam int TAP_BITS   = 16;
   localparam int KINV_BITS  = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam logic [PIX_BITS-1:0] PIX_MASK = PIX_BITS'((64'd1 << DEPTH_BITS) - 64'd1);

   // weight arithmetic
   localparam int DSQ_BITS    = 2 * PIX_BITS;
   localparam int NEAR_BITS   = 28;
   localparam int PROD_BITS   = NEAR_BITS + KINV_BITS;
   localparam int IDX_SHIFT   = 20;
   localparam int IDX_BITS    = PROD_BITS + 1 - IDX_SHIFT;
   localparam int EXP_IDX_BITS = $clog2(EXP_ENTRIES);
   localparam int TP_BITS     = 2 * TAP_BITS;
   localparam int WT_SHIFT    = 24;
   localparam int WT_BITS     = TP_BITS + PIX_BITS - WT_SHIFT;
   localparam int WV_BITS     = WT_BITS + PIX_BITS;
   localparam int ACC_GROW    = $clog2(TAP_COUNT);
   localparam int SW_BITS     = WT_BITS + ACC_GROW;
   localparam int SV_BITS     = WV_BITS + ACC_GROW;
   localparam int NUM_BITS    = SV_BITS + 1;

   // sequencing
   localparam int DRAIN_CYCLES = 8;
   localparam int STEP_MAX = (TAP_COUNT > NUM_BITS) ? TAP_COUNT : NUM_BITS;
   localparam int STEP_BITS = $clog2(STEP_MAX);

   // action codes
   localparam logic ACTION_PUSH  = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_TAP_0        = 3'd2,
      CSR_TAP_1        = 3'd3,
      CSR_TAP_2        = 3'd4,
      CSR_TAP_3        = 3'd5,
      CSR_RANGE_INV    = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_CHECK,
      ST_CENTRE,
      ST_SWEEP,
      ST_DRAIN,
      ST_DIVIDE,
      ST_DELIVER
   } ctrl_state_type;

   typedef struct packed {
      logic                action;
      logic [PIX_BITS-1:0] depth_mm;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] smoothed_depth;
      logic [POS_BITS-1:0] out_row;
      logic [POS_BITS-1:0] out_col;
      logic                frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic push;
      logic read_centre;
      logic load_centre;
      logic sweep_start;
      logic sweep_step;
      logic div_load;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic emit_ok;
      logic centre_zero;
      logic out_free;
   } ctrl_status_type;

   // exp(-i/16) in Q0.16, built by repeated multiplication by exp(-1/16) in Q0.32
   typedef logic [TAP_BITS-1:0] exp_rom_type [EXP_ENTRIES];

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [95:0] t;
      logic [95:0] e;
      t = 96'd1 << 32;
      for (int i = 0; i < EXP_ENTRIES; i++) begin
         e = (t + 96'd32768) >> 16;
         rom[i] = (e > 96'd65535) ? 16'hFFFF : e[15:0];
         t = (t * 96'd4034748382 + 96'd2147483648) >> 32;
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

// ===== rtl/bdsm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module bdsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/bdsm_ctrl.sv =====
// controller state machine of the depth smoother
// depends on bdsm_pkg; drives the datapath by commands only

module bdsm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bdsm_pkg::ctrl_status_type  status,
   output bdsm_pkg::ctrl_cmd_type     cmd
);

   bdsm_pkg::ctrl_state_type state_ff, state_in;
   logic [bdsm_pkg::STEP_BITS-1:0] step_ff, step_in;

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdsm_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_stall = (state_ff != bdsm_pkg::ST_IDLE);
      unique case (state_ff)
         bdsm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = bdsm_pkg::ST_PUSH;
            end
         end
         bdsm_pkg::ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = bdsm_pkg::ST_CHECK;
         end
         bdsm_pkg::ST_CHECK: begin
            if (status.emit_ok) begin
               cmd.read_centre = 1'b1;
               state_in        = bdsm_pkg::ST_CENTRE;
            end else begin
               state_in = bdsm_pkg::ST_IDLE;
            end
         end
         bdsm_pkg::ST_CENTRE: begin
            cmd.load_centre = 1'b1;
            step_in         = '0;
            if (status.centre_zero) begin
               state_in = bdsm_pkg::ST_DELIVER;
            end else begin
               cmd.sweep_start = 1'b1;
               state_in        = bdsm_pkg::ST_SWEEP;
            end
         end
         bdsm_pkg::ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (step_ff == bdsm_pkg::STEP_BITS'(bdsm_pkg::TAP_COUNT - 1)) begin
               step_in  = '0;
               state_in = bdsm_pkg::ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         bdsm_pkg::ST_DRAIN: begin
            if (step_ff == bdsm_pkg::STEP_BITS'(bdsm_pkg::DRAIN_CYCLES - 1)) begin
               cmd.div_load = 1'b1;
               step_in      = '0;
               state_in     = bdsm_pkg::ST_DIVIDE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         bdsm_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == bdsm_pkg::STEP_BITS'(bdsm_pkg::NUM_BITS - 1)) begin
               step_in  = '0;
               state_in = bdsm_pkg::ST_DELIVER;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         bdsm_pkg::ST_DELIVER: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = bdsm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bdsm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bdsm_datapath.sv =====
// datapath of the depth smoother: line store, counters, weight pipeline,
// accumulators, serial divider and output register; depends on bdsm_pkg, bdsm_ram

module bdsm_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bdsm_pkg::ctrl_cmd_type                 cmd,
   output bdsm_pkg::ctrl_status_type              status,
   input  bdsm_pkg::req_payload_type              req_payload,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [bdsm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bdsm_pkg::CSR_DATA_BITS-1:0]     csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bdsm_pkg::rsp_payload_type              rsp_payload
);

   localparam int H  = bdsm_pkg::HALF_WIDTH;
   localparam int PB = bdsm_pkg::PIX_BITS;
   localparam int SB = bdsm_pkg::SIZE_BITS;
   localparam int AB = bdsm_pkg::ADDR_BITS;

   // configuration registers
   logic [SB-1:0]                  frame_width_ff, frame_height_ff;
   logic [bdsm_pkg::TAP_BITS-1:0]  tap_ff [4];
   logic [bdsm_pkg::KINV_BITS-1:0] kinv_ff;
   logic                           csr_write, size_write;

   // frame position state
   logic [bdsm_pkg::POS_BITS-1:0]  in_row_ff, in_col_ff, out_row_ff, out_col_ff;
   logic [bdsm_pkg::RING_BITS-1:0] in_ring_ff, out_ring_ff;
   logic                           in_done_ff;
   logic [SB-1:0]                  eff_w, eff_h;
   logic [SB-1:0]                  in_col_next, in_row_next, out_col_next;
   logic [SB-1:0]                  last_row, last_col;
   logic                           do_push, out_last, restart;
   logic                           emit_ok;

   // captured transaction and centre
   logic                act_ff;
   logic [PB-1:0]       depth_ff;
   logic [PB-1:0]       centre_ff;

   // line store access
   logic [AB-1:0]       wr_addr, rd_addr, centre_addr, win_addr;
   logic                rd_en;
   logic [PB-1:0]       rd_data;

   // window tap sequencing
   logic [bdsm_pkg::OFF_BITS-1:0]      dr_ff, dc_ff, off_r, off_c;
   logic [SB-1:0]                      rr_off, cc_off, lr, lc;
   logic [bdsm_pkg::RING_SUM_BITS-1:0] ring_sum;
   logic                               in_window;
   logic [bdsm_pkg::TAP_BITS-1:0]      tap_r, tap_c;

   // weight pipeline
   logic                            s1_ok_ff;
   logic [bdsm_pkg::TAP_BITS-1:0]   s1_tapr_ff, s1_tapc_ff;
   logic                            s2_ok_ff;
   logic [PB-1:0]                   s2_d_ff, s2_v_ff;
   logic [bdsm_pkg::TP_BITS-1:0]    s2_tp_ff;
   logic                            s3_ok_ff;
   logic [bdsm_pkg::DSQ_BITS-1:0]   s3_dd_ff;
   logic [bdsm_pkg::TP_BITS-1:0]    s3_tp_ff;
   logic [PB-1:0]                   s3_v_ff;
   logic                            s4_ok_ff, s4_far_ff;
   logic [bdsm_pkg::PROD_BITS-1:0]  s4_prod_ff;
   logic [bdsm_pkg::TP_BITS-1:0]    s4_tp_ff;
   logic [PB-1:0]                   s4_v_ff;
   logic                            s5_ok_ff;
   logic [bdsm_pkg::TAP_BITS-1:0]   s5_e_ff;
   logic [bdsm_pkg::TP_BITS-1:0]    s5_tp_ff;
   logic [PB-1:0]                   s5_v_ff;
   logic                            s6_ok_ff;
   logic [bdsm_pkg::WT_BITS-1:0]    s6_wt_ff;
   logic [PB-1:0]                   s6_v_ff;
   logic                            s7_ok_ff;
   logic [bdsm_pkg::WT_BITS-1:0]    s7_wt_ff;
   logic [bdsm_pkg::WV_BITS-1:0]    s7_wv_ff;
   logic [bdsm_pkg::IDX_BITS-1:0]   exp_idx;
   logic [bdsm_pkg::TAP_BITS-1:0]   exp_val;
   logic [bdsm_pkg::TP_BITS+bdsm_pkg::TAP_BITS-1:0] wt_full;

   // accumulators and divider
   logic [bdsm_pkg::SW_BITS-1:0]  sw_ff, div_ff, rem_ff;
   logic [bdsm_pkg::SV_BITS-1:0]  sv_ff;
   logic [bdsm_pkg::NUM_BITS-1:0] num_ff;
   logic [bdsm_pkg::SW_BITS:0]    trial;
   logic                          trial_ge;
   logic                          zero_res_ff;
   logic [PB-1:0]                 result;

   // output register
   logic                       rsp_valid_ff;
   bdsm_pkg::rsp_payload_type  rsp_payload_ff;

   assign csr_write  = csr_valid && csr_ready;
   assign size_write = csr_write &&
                       (csr_index == bdsm_pkg::CSR_FRAME_WIDTH ||
                        csr_index == bdsm_pkg::CSR_FRAME_HEIGHT);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= SB'(640);
         frame_height_ff <= SB'(480);
         tap_ff[0]       <= 16'd65535;
         tap_ff[1]       <= 16'd39750;
         tap_ff[2]       <= 16'd8869;
         tap_ff[3]       <= 16'd728;
         kinv_ff         <= 24'd9320;
      end else if (csr_write) begin
         unique case (csr_index)
            bdsm_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[SB-1:0];
            bdsm_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[SB-1:0];
            bdsm_pkg::CSR_TAP_0:        tap_ff[0] <= csr_data[bdsm_pkg::TAP_BITS-1:0];
            bdsm_pkg::CSR_TAP_1:        tap_ff[1] <= csr_data[bdsm_pkg::TAP_BITS-1:0];
            bdsm_pkg::CSR_TAP_2:        tap_ff[2] <= csr_data[bdsm_pkg::TAP_BITS-1:0];
            bdsm_pkg::CSR_TAP_3:        tap_ff[3] <= csr_data[bdsm_pkg::TAP_BITS-1:0];
            bdsm_pkg::CSR_RANGE_INV:    kinv_ff   <= csr_data[bdsm_pkg::KINV_BITS-1:0];
            default: ;
         endcase
      end
   end

   // frame size clamped to the supported range
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = SB'(1);
      end else if (frame_width_ff > SB'(bdsm_pkg::WIDTH_LIMIT)) begin
         eff_w = SB'(bdsm_pkg::WIDTH_LIMIT);
      end else begin
         eff_w = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         eff_h = SB'(1);
      end else if (frame_height_ff > SB'(bdsm_pkg::HEIGHT_LIMIT)) begin
         eff_h = SB'(bdsm_pkg::HEIGHT_LIMIT);
      end else begin
         eff_h = frame_height_ff;
      end
   end

   // capture of the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_payload.action;
         depth_ff <= req_payload.depth_mm & bdsm_pkg::PIX_MASK;
      end
   end

   assign do_push     = cmd.push && (act_ff == bdsm_pkg::ACTION_PUSH) && !in_done_ff;
   assign in_col_next = SB'(in_col_ff) + SB'(1);
   assign in_row_next = SB'(in_row_ff) + SB'(1);
   assign out_col_next = SB'(out_col_ff) + SB'(1);
   assign last_row    = eff_h - SB'(1);
   assign last_col    = eff_w - SB'(1);
   assign out_last    = (SB'(out_row_ff) == last_row) && (SB'(out_col_ff) == last_col);
   assign restart     = size_write || (cmd.out_load && out_last);

   // input position counters
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         in_ring_ff <= '0;
         in_done_ff <= 1'b0;
      end else if (do_push) begin
         if (in_col_next >= eff_w) begin
            in_col_ff <= '0;
            if (in_row_next >= eff_h) begin
               in_row_ff  <= '0;
               in_ring_ff <= '0;
               in_done_ff <= 1'b1;
            end else begin
               in_row_ff  <= in_row_next[bdsm_pkg::POS_BITS-1:0];
               in_ring_ff <= (in_ring_ff == bdsm_pkg::RING_BITS'(bdsm_pkg::RING_ROWS - 1)) ?
                             '0 : in_ring_ff + 1'b1;
            end
         end else begin
            in_col_ff <= in_col_next[bdsm_pkg::POS_BITS-1:0];
         end
      end
   end

   // output position counters
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_ring_ff <= '0;
      end else if (cmd.out_load) begin
         if (out_col_next >= eff_w) begin
            out_col_ff  <= '0;
            out_row_ff  <= out_row_ff + 1'b1;
            out_ring_ff <= (out_ring_ff == bdsm_pkg::RING_BITS'(bdsm_pkg::RING_ROWS - 1)) ?
                           '0 : out_ring_ff + 1'b1;
         end else begin
            out_col_ff <= out_col_next[bdsm_pkg::POS_BITS-1:0];
         end
      end
   end

   // the window of the next output is complete once its bottom right pixel is in
   always_comb begin
      lr = SB'(out_row_ff) + SB'(H);
      if (!(lr < last_row)) lr = last_row;
      lc = SB'(out_col_ff) + SB'(H);
      if (!(lc < last_col)) lc = last_col;
      emit_ok = in_done_ff || (lr < SB'(in_row_ff)) ||
                ((lr == SB'(in_row_ff)) && (lc < SB'(in_col_ff)));
   end

   assign status.emit_ok = emit_ok;

   // window tap position, clipping, ring row and spatial taps
   always_comb begin
      rr_off   = SB'(out_row_ff) + SB'(dr_ff);
      cc_off   = SB'(out_col_ff) + SB'(dc_ff);
      in_window = (rr_off >= SB'(H)) && ((rr_off - SB'(H)) < eff_h) &&
                  (cc_off >= SB'(H)) && ((cc_off - SB'(H)) < eff_w);
      ring_sum = bdsm_pkg::RING_SUM_BITS'(out_ring_ff) + bdsm_pkg::RING_SUM_BITS'(dr_ff) +
                 bdsm_pkg::RING_SUM_BITS'(bdsm_pkg::RING_ROWS - H);
      if (ring_sum >= bdsm_pkg::RING_SUM_BITS'(bdsm_pkg::RING_ROWS))
         ring_sum = ring_sum - bdsm_pkg::RING_SUM_BITS'(bdsm_pkg::RING_ROWS);
      if (ring_sum >= bdsm_pkg::RING_SUM_BITS'(bdsm_pkg::RING_ROWS))
         ring_sum = ring_sum - bdsm_pkg::RING_SUM_BITS'(bdsm_pkg::RING_ROWS);
      win_addr = AB'(ring_sum[bdsm_pkg::RING_BITS-1:0]) * AB'(bdsm_pkg::MAX_WIDTH) +
                 AB'(cc_off - SB'(H));
      off_r = (dr_ff >= bdsm_pkg::OFF_BITS'(H)) ? dr_ff - bdsm_pkg::OFF_BITS'(H) :
                                                  bdsm_pkg::OFF_BITS'(H) - dr_ff;
      off_c = (dc_ff >= bdsm_pkg::OFF_BITS'(H)) ? dc_ff - bdsm_pkg::OFF_BITS'(H) :
                                                  bdsm_pkg::OFF_BITS'(H) - dc_ff;
      tap_r = (off_r < bdsm_pkg::OFF_BITS'(4)) ? tap_ff[off_r[1:0]] : '0;
      tap_c = (off_c < bdsm_pkg::OFF_BITS'(4)) ? tap_ff[off_c[1:0]] : '0;
   end

   // tap counters, row major over the window
   always_ff @(posedge clock) begin
      if (cmd.sweep_start) begin
         dr_ff <= '0;
         dc_ff <= '0;
      end else if (cmd.sweep_step) begin
         if (dc_ff == bdsm_pkg::OFF_BITS'(bdsm_pkg::WIN_SIZE - 1)) begin
            dc_ff <= '0;
            dr_ff <= dr_ff + 1'b1;
         end else begin
            dc_ff <= dc_ff + 1'b1;
         end
      end
   end

   // line store
   assign wr_addr     = AB'(in_ring_ff) * AB'(bdsm_pkg::MAX_WIDTH) + AB'(in_col_ff);
   assign centre_addr = AB'(out_ring_ff) * AB'(bdsm_pkg::MAX_WIDTH) + AB'(out_col_ff);
   assign rd_en       = cmd.read_centre || cmd.sweep_step;
   assign rd_addr     = cmd.read_centre ? centre_addr : win_addr;

   bdsm_ram #(
      .WIDTH (PB),
      .DEPTH (bdsm_pkg::LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_addr),
      .wr_data (depth_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.centre_zero = (rd_data == '0);

   always_ff @(posedge clock) begin
      if (cmd.load_centre) begin
         centre_ff <= rd_data;
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ok_ff <= 1'b0;
         s2_ok_ff <= 1'b0;
         s3_ok_ff <= 1'b0;
         s4_ok_ff <= 1'b0;
         s5_ok_ff <= 1'b0;
         s6_ok_ff <= 1'b0;
         s7_ok_ff <= 1'b0;
      end else begin
         s1_ok_ff <= cmd.sweep_step && in_window;
         s2_ok_ff <= s1_ok_ff && (rd_data != '0);
         s3_ok_ff <= s2_ok_ff;
         s4_ok_ff <= s3_ok_ff;
         s5_ok_ff <= s4_ok_ff;
         s6_ok_ff <= s5_ok_ff;
         s7_ok_ff <= s6_ok_ff;
      end
   end

   // range index rounded to 1/16, past the table weighs zero
   assign exp_idx = bdsm_pkg::IDX_BITS'(({1'b0, s4_prod_ff} +
                    (bdsm_pkg::PROD_BITS+1)'(1 << (bdsm_pkg::IDX_SHIFT - 1)))
                    >> bdsm_pkg::IDX_SHIFT);
   assign exp_val = (s4_far_ff || (exp_idx >= bdsm_pkg::IDX_BITS'(bdsm_pkg::EXP_ENTRIES))) ?
                    '0 : bdsm_pkg::EXP_ROM[exp_idx[bdsm_pkg::EXP_IDX_BITS-1:0]];
   assign wt_full = s5_tp_ff * s5_e_ff;

   // weight pipeline payload
   always_ff @(posedge clock) begin
      // taps and pixel read
      s1_tapr_ff <= tap_r;
      s1_tapc_ff <= tap_c;
      // difference and spatial product
      s2_d_ff  <= (rd_data > centre_ff) ? rd_data - centre_ff : centre_ff - rd_data;
      s2_tp_ff <= s1_tapr_ff * s1_tapc_ff;
      s2_v_ff  <= rd_data;
      // squared difference
      s3_dd_ff <= s2_d_ff * s2_d_ff;
      s3_tp_ff <= s2_tp_ff;
      s3_v_ff  <= s2_v_ff;
      // scale by 1/(2 sigma^2); a square this large is past the table for any nonzero k
      s4_far_ff  <= (s3_dd_ff[bdsm_pkg::DSQ_BITS-1:bdsm_pkg::NEAR_BITS] != '0) &&
                    (kinv_ff != '0);
      s4_prod_ff <= s3_dd_ff[bdsm_pkg::NEAR_BITS-1:0] * kinv_ff;
      s4_tp_ff   <= s3_tp_ff;
      s4_v_ff    <= s3_v_ff;
      // range weight from the table
      s5_e_ff  <= exp_val;
      s5_tp_ff <= s4_tp_ff;
      s5_v_ff  <= s4_v_ff;
      // combined weight
      s6_wt_ff <= wt_full[bdsm_pkg::TP_BITS+bdsm_pkg::TAP_BITS-1:bdsm_pkg::WT_SHIFT];
      s6_v_ff  <= s5_v_ff;
      // weighted value
      s7_wt_ff <= s6_wt_ff;
      s7_wv_ff <= s6_wt_ff * s6_v_ff;
   end

   // weight and weighted value sums
   always_ff @(posedge clock) begin
      if (cmd.sweep_start) begin
         sw_ff <= '0;
         sv_ff <= '0;
      end else if (s7_ok_ff) begin
         sw_ff <= sw_ff + bdsm_pkg::SW_BITS'(s7_wt_ff);
         sv_ff <= sv_ff + bdsm_pkg::SV_BITS'(s7_wv_ff);
      end
   end

   // restoring divider, one quotient bit per step
   assign trial    = {rem_ff, num_ff[bdsm_pkg::NUM_BITS-1]};
   assign trial_ge = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_ff <= bdsm_pkg::NUM_BITS'(sv_ff) + bdsm_pkg::NUM_BITS'(sw_ff >> 1);
         div_ff <= sw_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? bdsm_pkg::SW_BITS'(trial - {1'b0, div_ff}) :
                              bdsm_pkg::SW_BITS'(trial);
         num_ff <= {num_ff[bdsm_pkg::NUM_BITS-2:0], trial_ge};
      end
   end

   // invalid centre or empty weight sum gives zero
   always_ff @(posedge clock) begin
      if (cmd.load_centre) begin
         zero_res_ff <= (rd_data == '0);
      end else if (cmd.div_load) begin
         zero_res_ff <= (sw_ff == '0);
      end
   end

   // saturated quotient
   always_comb begin
      if (zero_res_ff) begin
         result = '0;
      end else if (num_ff[bdsm_pkg::NUM_BITS-1:PB] != '0) begin
         result = '1;
      end else begin
         result = num_ff[PB-1:0];
      end
   end

   // output register
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_payload_ff.smoothed_depth <= result;
         rsp_payload_ff.out_row        <= out_row_ff;
         rsp_payload_ff.out_col        <= out_col_ff;
         rsp_payload_ff.frame_last     <= out_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/bilateral_depth_smoother_unit.sv =====
// Bilateral depth smoother. Depth pixels arrive in raster order (0 = invalid)
// and each result is the bilateral-weighted mean over a 7x7 window clipped at
// the frame edges; a flush transaction drains one pending result at frame end.
// One transaction is in work at a time. One that yields no result ends at the
// window check, and one with an invalid centre goes to delivery. For a valid
// centre the single-read line store is swept at one window tap per cycle, the
// weight pipeline drains, the bit-serial divider runs and delivery waits on any
// output stall. A finished result waits in an output register
// while the next transaction is accepted. The line store needs no clearing
// pass after reset; writing frame_width or frame_height restarts the frame.
// Depends on bdsm_pkg, bdsm_ctrl, bdsm_datapath and assert_macros.svh.

`include "assert_macros.svh"

module bilateral_depth_smoother_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bdsm_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bdsm_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdsm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bdsm_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   bdsm_pkg::ctrl_cmd_type    cmd;
   bdsm_pkg::ctrl_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   // controller
   bdsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   bdsm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // design checks
   `BDSM_ASSERT_IMPLY(a_load_needs_room, clock, reset, cmd.out_load, status.out_free)
   `BDSM_ASSERT_NEXT(a_capture_then_push, clock, reset, cmd.capture, cmd.push)
   `BDSM_ASSERT_IMPLY(a_sweep_not_divide, clock, reset, cmd.sweep_step, !cmd.div_step)
   `BDSM_ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.out_load, rsp_valid)

endmodule

// ===== tb/sv/tb_bilateral_depth_smoother_unit.sv =====
// testbench for bilateral_depth_smoother_unit: checks smoothed depth results against a predictor
// depends on bdsm_pkg and the rtl of bilateral_depth_smoother_unit
`timescale 1ns / 100ps

module tb_bilateral_depth_smoother_unit;
   import bdsm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   bilateral_depth_smoother_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // pixel transactions waiting to be driven and smoothed results still owed
   req_payload_type pixel_queue[$];
   rsp_payload_type owed_results[$];
   int queued_count = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   bit req_taken = 1'b0;
   bit quiet_phase = 1'b0;
   bit long_hold_go = 1'b0;

   // predictor copy of registers and frame state
   logic [SIZE_BITS-1:0] p_width, p_height;
   logic [TAP_BITS-1:0] p_tap[4];
   logic [KINV_BITS-1:0] p_kinv;
   int p_in_row, p_in_col, p_out_idx;
   bit p_in_done;
   logic [PIX_BITS-1:0] depth_ring[RING_ROWS][MAX_WIDTH];
   logic [15:0] exp_tab[EXP_ENTRIES];

   function automatic int width_used();
      if (p_width < 1) return 1;
      return (p_width > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(p_width);
   endfunction

   function automatic int height_used();
      if (p_height < 1) return 1;
      return (p_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(p_height);
   endfunction

   function automatic void restart_frame();
      p_in_row = 0;
      p_in_col = 0;
      p_out_idx = 0;
      p_in_done = 1'b0;
   endfunction

   // weighted mean of the nonzero window pixels around (r, c)
   function automatic logic [15:0] smooth_at(int r, int c, int w, int h);
      logic [63:0] wsum, vsum, diff, idx, rweight, wt, res;
      logic [15:0] centre, v;
      int rr, cc, ar, ac;
      wsum = 0;
      vsum = 0;
      centre = depth_ring[r % RING_ROWS][c];
      if (centre == 0) return 16'd0;
      for (int dr = -HALF_WIDTH; dr <= HALF_WIDTH; dr++) begin
         rr = r + dr;
         if (rr < 0 || rr >= h) continue;
         for (int dc = -HALF_WIDTH; dc <= HALF_WIDTH; dc++) begin
            cc = c + dc;
            if (cc < 0 || cc >= w) continue;
            v = depth_ring[rr % RING_ROWS][cc];
            if (v == 0) continue;
            diff = (v > centre) ? 64'(v - centre) : 64'(centre - v);
            idx = (p_kinv == 0) ? 64'd0 : ((diff * diff * 64'(p_kinv) + 64'd524288) >> 20);
            rweight = (idx < EXP_ENTRIES) ? 64'(exp_tab[idx]) : 64'd0;
            ar = (dr < 0) ? -dr : dr;
            ac = (dc < 0) ? -dc : dc;
            wt = (64'(ar < 4 ? p_tap[ar] : 16'd0) * 64'(ac < 4 ? p_tap[ac] : 16'd0)
                  * rweight) >> 24;
            wsum += wt;
            vsum += wt * 64'(v);
         end
      end
      if (wsum == 0) return 16'd0;
      res = (vsum + wsum / 2) / wsum;
      return (res > 65535) ? 16'hFFFF : res[15:0];
   endfunction

   // emit the next result pixel once its window has arrived
   function automatic void try_emit();
      int w, h, total, pushed, r, c, lr, lc;
      rsp_payload_type exp_rsp;
      w = width_used();
      h = height_used();
      total = w * h;
      pushed = p_in_done ? total : p_in_row * w + p_in_col;
      if (p_out_idx >= total) begin
         restart_frame();
         return;
      end
      r = p_out_idx / w;
      c = p_out_idx % w;
      lr = (r + HALF_WIDTH < h - 1) ? r + HALF_WIDTH : h - 1;
      lc = (c + HALF_WIDTH < w - 1) ? c + HALF_WIDTH : w - 1;
      if (lr * w + lc >= pushed) return;
      exp_rsp.smoothed_depth = smooth_at(r, c, w, h);
      exp_rsp.out_row = POS_BITS'(r);
      exp_rsp.out_col = POS_BITS'(c);
      exp_rsp.frame_last = (p_out_idx == total - 1);
      owed_results.push_back(exp_rsp);
      if (exp_rsp.frame_last) restart_frame();
      else p_out_idx++;
   endfunction

   function automatic void predict_pixel(req_payload_type it);
      if (it.action == ACTION_PUSH && !p_in_done) begin
         depth_ring[p_in_row % RING_ROWS][p_in_col] = it.depth_mm;
         p_in_col++;
         if (p_in_col >= width_used()) begin
            p_in_col = 0;
            p_in_row++;
            if (p_in_row >= height_used()) begin
               p_in_row = 0;
               p_in_done = 1'b1;
            end
         end
      end
      try_emit();
   endfunction

   // acceptance and result checking at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_pixel(req_payload);
         req_taken = 1'b1;
         accepted_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_payload);
            mismatch_count++;
         end else begin
            rsp_payload_type e;
            e = owed_results.pop_front();
            if (rsp_payload.smoothed_depth !== e.smoothed_depth) begin
               $display("%0t: smoothed_depth expected %0d actual %0d", $time,
                        e.smoothed_depth, rsp_payload.smoothed_depth);
               mismatch_count++;
            end
            if (rsp_payload.out_row !== e.out_row) begin
               $display("%0t: out_row expected %0d actual %0d", $time,
                        e.out_row, rsp_payload.out_row);
               mismatch_count++;
            end
            if (rsp_payload.out_col !== e.out_col) begin
               $display("%0t: out_col expected %0d actual %0d", $time,
                        e.out_col, rsp_payload.out_col);
               mismatch_count++;
            end
            if (rsp_payload.frame_last !== e.frame_last) begin
               $display("%0t: frame_last expected %0d actual %0d", $time,
                        e.frame_last, rsp_payload.frame_last);
               mismatch_count++;
            end
         end
      end
   end

   // pixel driver with random gap bursts
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() > 0 && !quiet_phase && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 4);
            req_valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_payload <= pixel_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall bursts and one long hold-off
   int stall_left = 0;
   always @(negedge clock) begin
      if (long_hold_go) begin
         long_hold_go = 1'b0;
         stall_left = 600;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic wait_idle();
      wait (accepted_count == queued_count && owed_results.size() == 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH: begin p_width = value[SIZE_BITS-1:0]; restart_frame(); end
         CSR_FRAME_HEIGHT: begin p_height = value[SIZE_BITS-1:0]; restart_frame(); end
         CSR_TAP_0: p_tap[0] = value[TAP_BITS-1:0];
         CSR_TAP_1: p_tap[1] = value[TAP_BITS-1:0];
         CSR_TAP_2: p_tap[2] = value[TAP_BITS-1:0];
         CSR_TAP_3: p_tap[3] = value[TAP_BITS-1:0];
         CSR_RANGE_INV: p_kinv = value[KINV_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_item(logic act, logic [15:0] depth);
      req_payload_type it;
      it.action = act;
      it.depth_mm = depth;
      pixel_queue.push_back(it);
      queued_count++;
   endfunction

   // mostly depths near a surface level, with holes, extremes and noise
   function automatic logic [15:0] pick_depth(logic [15:0] level);
      case ($urandom_range(0, 19))
         0, 1: return 16'd0;
         2: return 16'hFFFF;
         3: return 16'd1;
         4, 5: return 16'($urandom_range(0, 65535));
         default: return level + 16'($urandom_range(0, 60)) - 16'd30;
      endcase
   endfunction

   // one frame of pushes with stray flushes, then enough flushes to drain it; a cut-short frame stops early, undrained
   task automatic add_frame(int w, int h, bit cut_short);
      logic [15:0] level;
      int n;
      level = 16'($urandom_range(200, 60000));
      n = cut_short ? $urandom_range(1, w * h) : w * h;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) add_item(ACTION_FLUSH, 16'($urandom));
         add_item(ACTION_PUSH, pick_depth(level));
      end
      if (!cut_short) begin
         for (int i = 0; i < 3 * w + 4; i++) add_item(ACTION_FLUSH, 16'($urandom));
      end
   endtask

   task automatic set_frame(int w, int h);
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_BITS'(w));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(h));
   endtask

   // main sequence
   initial begin
      logic [95:0] t, e;
      int w, h;
      t = 96'd1 << 32;
      for (int i = 0; i < EXP_ENTRIES; i++) begin
         e = (t + 96'd32768) >> 16;
         exp_tab[i] = (e > 96'd65535) ? 16'hFFFF : e[15:0];
         t = (t * 96'd4034748382 + 96'd2147483648) >> 32;
      end
      p_width = 11'd640;
      p_height = 11'd480;
      p_tap[0] = 16'd65535;
      p_tap[1] = 16'd39750;
      p_tap[2] = 16'd8869;
      p_tap[3] = 16'd728;
      p_kinv = 24'd9320;
      restart_frame();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default geometry: a partial row gives nothing, flush too early gives nothing
      add_item(ACTION_PUSH, 16'd1000);
      add_item(ACTION_PUSH, 16'hFFFF);
      add_item(ACTION_FLUSH, 16'hFFFF);
      add_item(ACTION_PUSH, 16'd0);
      wait_idle();

      // small frame with invalid centre, extremes, and a push after the frame
      set_frame(4, 3);
      add_item(ACTION_PUSH, 16'd1000);
      add_item(ACTION_PUSH, 16'd0);
      add_item(ACTION_FLUSH, 16'd0);
      add_item(ACTION_PUSH, 16'hFFFF);
      add_item(ACTION_PUSH, 16'd1);
      for (int i = 0; i < 8; i++) add_item(ACTION_PUSH, 16'd1000 + 16'(i * 3));
      add_item(ACTION_PUSH, 16'd1234);
      for (int i = 0; i < 8; i++) add_item(ACTION_FLUSH, 16'h0);
      wait_idle();

      // zero taps: every weight sum is zero; widest range factor: only depths within 3 of the centre count
      write_csr(CSR_TAP_0, 24'd0);
      write_csr(CSR_TAP_1, 24'd0);
      write_csr(CSR_TAP_2, 24'd0);
      write_csr(CSR_TAP_3, 24'd0);
      set_frame(2, 2);
      for (int i = 0; i < 4; i++) add_item(ACTION_PUSH, 16'd500);
      wait_idle();
      write_csr(CSR_TAP_0, 24'hFFFF);
      write_csr(CSR_TAP_1, 24'hFFFF);
      write_csr(CSR_TAP_2, 24'hFFFF);
      write_csr(CSR_TAP_3, 24'hFFFF);
      write_csr(CSR_RANGE_INV, 24'hFFFFFF);
      set_frame(1, 1);
      add_item(ACTION_PUSH, 16'd700);
      add_item(ACTION_FLUSH, 16'd0);
      wait_idle();

      // out-of-range sizes clamp to the widest row and a single row
      set_frame(2047, 0);
      for (int i = 0; i < 10; i++) add_item(ACTION_PUSH, 16'd3000 + 16'(i));
      add_item(ACTION_FLUSH, 16'd0);
      wait_idle();
      set_frame(1024, 1024);
      for (int i = 0; i < 6; i++) add_item(ACTION_PUSH, 16'd0);
      wait_idle();

      // random frames with occasional register changes
      for (int frame = 0; queued_count < 1850; frame++) begin
         if (frame % 4 == 0) begin
            wait_idle();
            w = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 12);
            h = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 8);
            set_frame(w, h);
            write_csr(CSR_TAP_0, CSR_DATA_BITS'($urandom_range(0, 65535)));
            write_csr(CSR_TAP_1, CSR_DATA_BITS'($urandom_range(0, 65535)));
            write_csr(CSR_TAP_2, CSR_DATA_BITS'($urandom_range(0, 65535)));
            write_csr(CSR_TAP_3, $urandom_range(0, 3) == 0 ? 24'd0
                                 : CSR_DATA_BITS'($urandom_range(0, 65535)));
            case ($urandom_range(0, 4))
               0: write_csr(CSR_RANGE_INV, 24'd0);
               1: write_csr(CSR_RANGE_INV, 24'hFFFFFF);
               2: write_csr(CSR_RANGE_INV, CSR_DATA_BITS'($urandom_range(0, 16777215)));
               default: write_csr(CSR_RANGE_INV, CSR_DATA_BITS'($urandom_range(100, 40000)));
            endcase
         end
         if (frame == 6) long_hold_go = 1'b1;
         if (frame % 4 == 3 && $urandom_range(0, 2) == 0) begin
            // broken frame, abandoned by the next size write
            add_frame(width_used(), height_used(), 1'b1);
            frame = frame | 3;
         end else begin
            add_frame(width_used(), height_used(), 1'b0);
         end
         if (queued_count > 1600) quiet_phase = 1'b1;
      end

      wait (accepted_count == queued_count && owed_results.size() == 0);
      repeat (150) @(posedge clock);
      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bdsm_pkg.sv
rtl/bdsm_ram.sv
rtl/bdsm_ctrl.sv
rtl/bdsm_datapath.sv
rtl/bilateral_depth_smoother_unit.sv
tb/sv/tb_bilateral_depth_smoother_unit.sv
